// ===== src/bchd_pkg.sv =====
// Shared types and constants for the button click and hold detector.
// No dependencies; the design files refer to it by scoped names, the dv files import it.
package bchd_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int PIN_W       = 4;
   localparam int MASK_W      = 4;
   localparam int TIME_W      = 32;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CFG_W-1:0] SCAN_INTERVAL_RESET = CFG_W'(10);
   localparam logic [CFG_W-1:0] HOLD_LIMIT_RESET    = CFG_W'(1000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_INTERVAL = 1'b0,
      CSR_HOLD_LIMIT    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_IDLE  = 2'd0,
      EV_CLICK = 2'd1,
      EV_HELD  = 2'd2
   } event_type;

   typedef struct packed {
      logic fire;
      logic scan;
      logic pressed;
      logic take;
   } lane_ctl_type;

   typedef struct packed {
      logic clicked;
      logic held;
   } lane_flag_type;

   typedef struct packed {
      logic [MASK_W-1:0] clicked_mask;
      logic [MASK_W-1:0] held_mask;
      logic              scanned;
   } rsp_word_type;

endpackage

// ===== src/bchd_lane.sv =====
// One button lane: press tracking, press start time and event code.
// Depends on bchd_pkg.
module bchd_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  bchd_pkg::lane_ctl_type        ctl,
   input  logic [bchd_pkg::TIME_W-1:0]   now_ms,
   input  logic [bchd_pkg::CFG_W-1:0]    hold_limit,
   output bchd_pkg::lane_flag_type       flags
);

   logic                          was_pressed_ff;
   logic                          was_pressed_in;
   logic [bchd_pkg::TIME_W-1:0]   press_start_ff;
   logic [bchd_pkg::TIME_W-1:0]   press_start_in;
   bchd_pkg::event_type           event_ff;
   bchd_pkg::event_type           event_in;

   logic                          new_press;
   logic                          over_limit;
   logic [bchd_pkg::TIME_W-1:0]   held_for;
   bchd_pkg::event_type           scan_event;
   bchd_pkg::event_type           report;

   always_comb begin
      new_press  = ctl.pressed && !was_pressed_ff;
      held_for   = now_ms - press_start_ff;
      over_limit = !new_press &&
                   (held_for > {{(bchd_pkg::TIME_W-bchd_pkg::CFG_W){1'b0}}, hold_limit});

      scan_event = event_ff;
      if (!ctl.pressed && was_pressed_ff) begin
         scan_event = over_limit ? bchd_pkg::EV_IDLE : bchd_pkg::EV_CLICK;
      end
      if (ctl.pressed && over_limit) begin
         scan_event = bchd_pkg::EV_HELD;
      end

      report        = ctl.scan ? scan_event : event_ff;
      flags.clicked = (report == bchd_pkg::EV_CLICK);
      flags.held    = (report == bchd_pkg::EV_HELD);

      // drop a consumed click
      event_in       = (flags.clicked && ctl.take) ? bchd_pkg::EV_IDLE : report;
      was_pressed_in = ctl.scan ? ctl.pressed : was_pressed_ff;
      press_start_in = (ctl.scan && new_press) ? now_ms : press_start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= 1'b0;
         press_start_ff <= '0;
         event_ff       <= bchd_pkg::EV_IDLE;
      end else if (ctl.fire) begin
         was_pressed_ff <= was_pressed_in;
         press_start_ff <= press_start_in;
         event_ff       <= event_in;
      end
   end

endmodule

// ===== src/bchd_merge.sv =====
// Merges lane flags into the result word and buffers two result words.
// Depends on bchd_pkg.
module bchd_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         push,
   input  logic                                         scanned,
   input  bchd_pkg::lane_flag_type [bchd_pkg::NUM_BUTTONS-1:0] flags,
   output logic                                         space,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [bchd_pkg::MASK_W-1:0]                  rsp_clicked_mask,
   output logic [bchd_pkg::MASK_W-1:0]                  rsp_held_mask,
   output logic                                         rsp_scanned
);

   bchd_pkg::rsp_word_type word;
   bchd_pkg::rsp_word_type fifo_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic                   pop;

   genvar gi;
   generate
      for (gi = 0; gi < bchd_pkg::MASK_W; gi++) begin : g_mask
         if (gi < bchd_pkg::NUM_BUTTONS) begin : g_live
            assign word.clicked_mask[gi] = flags[gi].clicked;
            assign word.held_mask[gi]    = flags[gi].held;
         end else begin : g_none
            assign word.clicked_mask[gi] = 1'b0;
            assign word.held_mask[gi]    = 1'b0;
         end
      end
   endgenerate

   assign word.scanned = scanned;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_clicked_mask = fifo_ff[rd_ptr_ff].clicked_mask;
   assign rsp_held_mask    = fifo_ff[rd_ptr_ff].held_mask;
   assign rsp_scanned      = fifo_ff[rd_ptr_ff].scanned;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

// ===== src/button_click_hold_detector.sv =====
// Top level of the button click and hold detector: scan timer, settings,
// button lanes and result buffer. Depends on bchd_pkg, bchd_lane, bchd_merge.
//
// One request word enters per clock cycle while req_ready is high; its
// response is registered on acceptance. Every button has its own lane that
// resolves its press time compare and event update in the accepting cycle,
// so that rate holds regardless of the button count. A two-word response
// buffer keeps requests flowing while a response waits; req_ready drops only
// when both buffer entries are occupied. The user must write settings through
// the csr port while no request is in flight; the block does not enforce it.
module button_click_hold_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bchd_pkg::TIME_W-1:0]           req_now_ms,
   input  logic [bchd_pkg::PIN_W-1:0]            req_pin_levels,
   input  logic [bchd_pkg::PIN_W-1:0]            req_take_clicks,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bchd_pkg::MASK_W-1:0]           rsp_clicked_mask,
   output logic [bchd_pkg::MASK_W-1:0]           rsp_held_mask,
   output logic                                  rsp_scanned,
   input  logic                                  csr_write_enable,
   input  logic [bchd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bchd_pkg::CFG_W-1:0]            csr_write_data
);

   logic [bchd_pkg::CFG_W-1:0]   scan_interval_ff;
   logic [bchd_pkg::CFG_W-1:0]   hold_limit_ff;
   logic [bchd_pkg::TIME_W-1:0]  last_scan_ff;
   logic [bchd_pkg::TIME_W-1:0]  since_scan;
   logic                         scan_hit;
   logic                         accept;

   bchd_pkg::lane_ctl_type  [bchd_pkg::NUM_BUTTONS-1:0] lane_ctl;
   bchd_pkg::lane_flag_type [bchd_pkg::NUM_BUTTONS-1:0] lane_flags;

   assign accept     = req_valid && req_ready;
   assign since_scan = req_now_ms - last_scan_ff;
   assign scan_hit   = since_scan >=
                       {{(bchd_pkg::TIME_W-bchd_pkg::CFG_W){1'b0}}, scan_interval_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_interval_ff <= bchd_pkg::SCAN_INTERVAL_RESET;
         hold_limit_ff    <= bchd_pkg::HOLD_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (bchd_pkg::csr_index_type'(csr_index))
            bchd_pkg::CSR_SCAN_INTERVAL: scan_interval_ff <= csr_write_data;
            bchd_pkg::CSR_HOLD_LIMIT:    hold_limit_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scan_ff <= '0;
      end else if (accept && scan_hit) begin
         last_scan_ff <= req_now_ms;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < bchd_pkg::NUM_BUTTONS; gi++) begin : g_lane
         assign lane_ctl[gi].fire = accept;
         assign lane_ctl[gi].scan = scan_hit;
         if (gi < bchd_pkg::PIN_W) begin : g_pin
            assign lane_ctl[gi].pressed = !req_pin_levels[gi];
            assign lane_ctl[gi].take    = req_take_clicks[gi];
         end else begin : g_nopin
            assign lane_ctl[gi].pressed = 1'b1;
            assign lane_ctl[gi].take    = 1'b0;
         end

         bchd_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctl        (lane_ctl[gi]),
            .now_ms     (req_now_ms),
            .hold_limit (hold_limit_ff),
            .flags      (lane_flags[gi])
         );
      end
   endgenerate

   bchd_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .push             (accept),
      .scanned          (scan_hit),
      .flags            (lane_flags),
      .space            (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_clicked_mask (rsp_clicked_mask),
      .rsp_held_mask    (rsp_held_mask),
      .rsp_scanned      (rsp_scanned)
   );

   a_full_has_word: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("buffer full without a pending response word");

   a_scan_time: assert property (@(posedge clock) disable iff (reset)
      accept && scan_hit |=> last_scan_ff == $past(req_now_ms))
      else $error("scan time not recorded");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(last_scan_ff))
      else $error("scan time moved without a request");

   a_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_clicked_mask & rsp_held_mask) == '0)
      else $error("button reported both clicked and held");

endmodule

// ===== dv/bchd_tracker_pkg.sv =====
// Tracks button press state and event codes to predict the detector's response words.
// Depends on bchd_pkg for widths, the csr index enum, event codes and the response word.
package bchd_tracker_pkg;

   import bchd_pkg::*;

   class button_event_tracker;
      logic [CFG_W-1:0]  scan_interval;
      logic [CFG_W-1:0]  hold_limit;
      logic [TIME_W-1:0] last_scan;
      logic              was_down [NUM_BUTTONS];
      logic [TIME_W-1:0] press_start [NUM_BUTTONS];
      event_type         press_event [NUM_BUTTONS];
      rsp_word_type      expected_reports [$];
      int                mismatches;
      int                words_checked;
      int                scans_seen;
      int                click_reports;
      int                held_reports;

      function new();
         clear();
         mismatches    = 0;
         words_checked = 0;
         scans_seen    = 0;
         click_reports = 0;
         held_reports  = 0;
      endfunction

      function void clear();
         scan_interval = SCAN_INTERVAL_RESET;
         hold_limit    = HOLD_LIMIT_RESET;
         last_scan     = '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            was_down[i]    = 1'b0;
            press_start[i] = '0;
            press_event[i] = EV_IDLE;
         end
         expected_reports.delete();
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_SCAN_INTERVAL: scan_interval = value;
            CSR_HOLD_LIMIT:    hold_limit = value;
            default: ;
         endcase
      endfunction

      function void note_request(logic [TIME_W-1:0] now, logic [PIN_W-1:0] pins,
                                 logic [PIN_W-1:0] take);
         rsp_word_type      word;
         logic [TIME_W-1:0] held_for;
         logic              down;
         word = '0;
         if (TIME_W'(now - last_scan) >= TIME_W'(scan_interval)) begin
            last_scan    = now;
            word.scanned = 1'b1;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
               down = (i < PIN_W) ? !pins[i] : 1'b1;
               if (down && !was_down[i])
                  press_start[i] = now;
               held_for = now - press_start[i];
               if (!down && was_down[i])
                  press_event[i] = (held_for <= TIME_W'(hold_limit)) ? EV_CLICK : EV_IDLE;
               if (down && held_for > TIME_W'(hold_limit))
                  press_event[i] = EV_HELD;
               was_down[i] = down;
            end
         end
         for (int i = 0; i < NUM_BUTTONS && i < MASK_W; i++) begin
            if (press_event[i] == EV_CLICK) begin
               word.clicked_mask[i] = 1'b1;
               if (i < PIN_W && take[i])
                  press_event[i] = EV_IDLE;
            end else if (press_event[i] == EV_HELD) begin
               word.held_mask[i] = 1'b1;
            end
         end
         expected_reports.push_back(word);
      endfunction

      function void compare_field(string name, logic [MASK_W-1:0] want,
                                  logic [MASK_W-1:0] got, realtime stamp);
         if (want !== got) begin
            $display("%0.1f ns: %s mismatch, expected %h, actual %h", stamp, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_report(logic [MASK_W-1:0] clicked, logic [MASK_W-1:0] held,
                                 logic scanned, realtime stamp);
         rsp_word_type want;
         if (expected_reports.size() == 0) begin
            $display("%0.1f ns: unexpected word, expected none, actual clicked %h held %h scanned %b",
                     stamp, clicked, held, scanned);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         compare_field("clicked_mask", want.clicked_mask, clicked, stamp);
         compare_field("held_mask", want.held_mask, held, stamp);
         compare_field("scanned", MASK_W'(want.scanned), MASK_W'(scanned), stamp);
         words_checked++;
         if (want.scanned)
            scans_seen++;
         if (want.clicked_mask != '0)
            click_reports++;
         if (want.held_mask != '0)
            held_reports++;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

endpackage

// ===== dv/tb.sv =====
// Top-level bench for button_click_hold_detector: directed and random request words,
// random stalls on both channels, csr phases. Depends on bchd_pkg and bchd_tracker_pkg.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import bchd_pkg::*;
   import bchd_tracker_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_WORDS = 210;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic [PIN_W-1:0]     req_pin_levels = '1;
   logic [PIN_W-1:0]     req_take_clicks = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [MASK_W-1:0]    rsp_clicked_mask;
   logic [MASK_W-1:0]    rsp_held_mask;
   logic                 rsp_scanned;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_write_data = '0;

   button_event_tracker tracker = new();
   bit                  steady = 1'b0;
   int                  stall_count = 0;
   int                  settings_used = 1;
   logic [TIME_W-1:0]   now_ms = '0;
   logic [PIN_W-1:0]    pins = '1;

   button_click_hold_detector i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ms       (req_now_ms),
      .req_pin_levels   (req_pin_levels),
      .req_take_clicks  (req_take_clicks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_clicked_mask (rsp_clicked_mask),
      .rsp_held_mask    (rsp_held_mask),
      .rsp_scanned      (rsp_scanned),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 11);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_now_ms, req_pin_levels, req_take_clicks);
         if (rsp_valid && rsp_ready)
            tracker.check_report(rsp_clicked_mask, rsp_held_mask, rsp_scanned, $realtime);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("%0.1f ns: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [TIME_W-1:0] at_ms, input logic [PIN_W-1:0] levels,
                            input logic [PIN_W-1:0] take);
      while (!steady && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_now_ms      <= at_ms;
      req_pin_levels  <= levels;
      req_take_clicks <= take;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input logic [CFG_W-1:0] scan, input logic [CFG_W-1:0] hold);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCAN_INTERVAL;
      csr_write_data   <= scan;
      tracker.set_register(CSR_SCAN_INTERVAL, scan);
      @(posedge clock);
      csr_index      <= CSR_HOLD_LIMIT;
      csr_write_data <= hold;
      tracker.set_register(CSR_HOLD_LIMIT, hold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int count);
      int unsigned scan;
      int unsigned hold;
      int unsigned roll;
      scan = 32'(tracker.scan_interval);
      hold = 32'(tracker.hold_limit);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            now_ms = $urandom();
            pins   = PIN_W'($urandom());
         end else begin
            if (roll < 15)
               now_ms += $urandom_range(0, hold + hold / 2 + 4);
            else
               now_ms += $urandom_range(0, 2 * scan + 3);
            for (int i = 0; i < PIN_W; i++)
               if ($urandom_range(0, 5) == 0)
                  pins[i] = ~pins[i];
         end
         send_word(now_ms, pins, PIN_W'($urandom()));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(32'd0, 4'hF, 4'h0);
      send_word(32'd9, 4'hF, 4'h0);
      send_word(32'd10, 4'h0, 4'h0);
      send_word(32'd1010, 4'hF, 4'h0);
      send_word(32'd1011, 4'hF, 4'b0101);
      send_word(32'd1012, 4'hF, 4'hF);
      send_word(32'd1030, 4'h0, 4'hF);
      send_word(32'd2031, 4'h0, 4'h0);
      send_word(32'd2035, 4'h0, 4'hF);
      send_word(32'd2050, 4'hF, 4'hF);
      send_word(32'hFFFF_FFF0, 4'b1010, 4'h0);
      send_word(32'h0000_0005, 4'hF, 4'h0);
      send_word(32'hFFFF_FFFF, 4'b0101, 4'b1010);
      now_ms = 32'h0000_1000;
      pins   = 4'hF;
      run_phase(PHASE_WORDS);

      settle();
      load_settings(16'd0, 16'd0);
      now_ms = 32'h8000_0000;
      send_word(now_ms, 4'h0, 4'h0);
      send_word(now_ms, 4'hF, 4'h0);
      send_word(now_ms + 1, 4'h0, 4'hF);
      send_word(now_ms + 2, 4'h0, 4'h0);
      send_word(now_ms + 2, 4'h5, 4'hF);
      now_ms += 2;
      run_phase(PHASE_WORDS);

      settle();
      load_settings(16'd0, 16'd65535);
      run_phase(PHASE_WORDS);

      settle();
      load_settings(16'd65535, 16'd65535);
      steady = 1'b1;
      run_phase(PHASE_WORDS);
      steady = 1'b0;

      settle();
      load_settings(16'd65535, 16'd0);
      run_phase(PHASE_WORDS);

      settle();
      load_settings(16'd3, 16'd25);
      run_phase(PHASE_WORDS);

      settle();
      load_settings(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 3000)));
      run_phase(PHASE_WORDS);

      settle();
      load_settings(CFG_W'($urandom()), CFG_W'($urandom()));
      run_phase(PHASE_WORDS);

      settle();
      $display("covered %0d words over %0d csr settings: %0d scans,",
               tracker.words_checked, settings_used, tracker.scans_seen);
      $display("%0d click and %0d held reports, mismatches %0d, words still expected %0d",
               tracker.click_reports, tracker.held_reports, tracker.mismatches,
               tracker.pending());
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
